// ===== src/pm_pkg.sv =====
// shared types and constants for the polynomial multiplier
package pm_pkg;

   localparam int MAX_TERMS_DEFAULT  = 32;
   localparam int COEF_WIDTH_DEFAULT = 32;
   localparam int COEF_PORT_WIDTH    = 32;
   localparam int RSP_WIDTH          = 64;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // control tag that travels with each product term down the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last_k;
      logic last_all;
   } tag_type;

endpackage

// ===== src/pm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module pm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pm_mac.sv =====
// shared multiply-accumulate unit with 64-bit saturation of each finished sum
module pm_mac
   import pm_pkg::*;
#(
   parameter int MAX_TERMS  = MAX_TERMS_DEFAULT,
   parameter int COEF_WIDTH = COEF_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COEF_WIDTH-1:0] op_a,
   input  logic [COEF_WIDTH-1:0] op_b,
   input  tag_type               tag,
   output logic                  rsp_valid,
   output logic [RSP_WIDTH-1:0]  rsp_coef_out,
   output logic                  rsp_last_out,
   output logic                  rsp_saturated
);

   localparam int PROD_W = 2 * COEF_WIDTH;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TERMS) + 1;
   localparam int SAT_W  = (ACC_W > RSP_WIDTH) ? ACC_W : RSP_WIDTH + 1;

   localparam logic [RSP_WIDTH-1:0] POS_LIMIT = {1'b0, {(RSP_WIDTH-1){1'b1}}};
   localparam logic [RSP_WIDTH-1:0] NEG_LIMIT = {1'b1, {(RSP_WIDTH-1){1'b0}}};

   logic signed [COEF_WIDTH-1:0] a_s;
   logic signed [COEF_WIDTH-1:0] b_s;
   logic signed [PROD_W-1:0]     prod_in;
   logic signed [PROD_W-1:0]     prod_ff;
   tag_type                      tag_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic signed [SAT_W-1:0]      acc_ext;
   logic                         fits;

   logic                         valid_ff;
   logic [RSP_WIDTH-1:0]         coef_ff;
   logic                         last_ff;
   logic                         sat_ff;

   assign a_s     = op_a;
   assign b_s     = op_b;
   assign prod_in = a_s * b_s;

   assign acc_in  = tag_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
   assign acc_ext = SAT_W'(acc_in);
   // the sum fits when every bit above the 64-bit sign bit matches it
   assign fits    = (&acc_ext[SAT_W-1:RSP_WIDTH-1]) | ~(|acc_ext[SAT_W-1:RSP_WIDTH-1]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (tag_ff.valid && tag_ff.last_k) begin
         coef_ff <= fits ? acc_ext[RSP_WIDTH-1:0]
                         : (acc_ext[SAT_W-1] ? NEG_LIMIT : POS_LIMIT);
         sat_ff  <= ~fits;
         last_ff <= tag_ff.last_all;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tag_ff   <= tag;
         valid_ff <= tag_ff.valid && tag_ff.last_k;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_coef_out  = coef_ff;
   assign rsp_last_out  = last_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== src/polynomial_multiply.sv =====
// polynomial multiplier: top level with operand stores and convolution sequencer
// loading: one coefficient per cycle while busy is low.
// once both operands are complete, busy rises and one multiply-accumulate per cycle runs
// over all la*lb term pairs; the first product coefficient passes the stores' registered read,
// the mac's product register and its result register; busy stays high until the last result is out.
// results come as one-cycle strobes on rsp_valid; the receiver cannot stall.
// synchronous reset clears lengths, done marks, drop flag and the sequencer.
module polynomial_multiply
   import pm_pkg::*;
#(
   parameter int MAX_TERMS  = MAX_TERMS_DEFAULT,
   parameter int COEF_WIDTH = COEF_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic [COEF_PORT_WIDTH-1:0] req_coef_in,
   input  logic                       req_last_coef,
   output logic                       rsp_valid,
   output logic [RSP_WIDTH-1:0]       rsp_coef_out,
   output logic                       rsp_last_out,
   output logic                       rsp_saturated,
   output logic                       rsp_terms_dropped
);

   localparam int AW    = $clog2(MAX_TERMS);
   localparam int LEN_W = $clog2(MAX_TERMS + 1);
   localparam int SEQ_W = $clog2(2 * MAX_TERMS - 1) + 1;

   localparam logic [AW-1:0]    ADDR_MASK = AW'(MAX_TERMS - 1);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_TERMS);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_a_ff, len_a_in;
   logic [LEN_W-1:0] len_b_ff, len_b_in;
   logic             done_a_ff, done_a_in;
   logic             done_b_ff, done_b_in;
   logic             drop_ff, drop_in;
   logic [SEQ_W-1:0] k_ff, k_in;
   logic [AW-1:0]    y_ff, y_in;
   logic             first_ff, first_in;
   tag_type          tag_issue;
   tag_type          tag_rd_ff;

   logic             wr_a;
   logic             wr_b;
   logic             rd_en;
   logic [SEQ_W-1:0] la_s, lb_s, y_s, x_s, ymax_s, k_next, ymin_next_s;
   logic             last_y;
   logic             last_all_k;
   logic [AW-1:0]    rd_addr_a;
   logic [AW-1:0]    rd_addr_b;
   logic [COEF_WIDTH-1:0] data_a;
   logic [COEF_WIDTH-1:0] data_b;

   assign la_s        = SEQ_W'(len_a_ff);
   assign lb_s        = SEQ_W'(len_b_ff);
   assign y_s         = SEQ_W'(y_ff);
   assign x_s         = k_ff - y_s;
   assign ymax_s      = (k_ff < la_s) ? k_ff : la_s - SEQ_W'(1);
   assign k_next      = k_ff + SEQ_W'(1);
   assign ymin_next_s = (k_next >= lb_s) ? k_next - lb_s + SEQ_W'(1) : '0;
   assign last_y      = (y_s == ymax_s);
   assign last_all_k  = (k_ff == la_s + lb_s - SEQ_W'(2));
   assign rd_addr_a   = y_ff & ADDR_MASK;
   assign rd_addr_b   = x_s[AW-1:0] & ADDR_MASK;
   assign rd_en       = (state_ff == ST_RUN);

   always_comb begin
      state_in  = state_ff;
      len_a_in  = len_a_ff;
      len_b_in  = len_b_ff;
      done_a_in = done_a_ff;
      done_b_in = done_b_ff;
      drop_in   = drop_ff;
      k_in      = k_ff;
      y_in      = y_ff;
      first_in  = first_ff;
      tag_issue = '0;
      wr_a      = 1'b0;
      wr_b      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               // coefficients for an operand already marked done are ignored
               if (!req_type && !done_a_ff) begin
                  if (len_a_ff < LEN_MAX) begin
                     wr_a     = 1'b1;
                     len_a_in = len_a_ff + LEN_W'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
                  if (req_last_coef) begin
                     done_a_in = 1'b1;
                  end
               end else if (req_type && !done_b_ff) begin
                  if (len_b_ff < LEN_MAX) begin
                     wr_b     = 1'b1;
                     len_b_in = len_b_ff + LEN_W'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
                  if (req_last_coef) begin
                     done_b_in = 1'b1;
                  end
               end
               if (done_a_in && done_b_in) begin
                  state_in = ST_RUN;
                  k_in     = '0;
                  y_in     = '0;
                  first_in = 1'b1;
               end
            end
         end
         ST_RUN: begin
            tag_issue.valid    = 1'b1;
            tag_issue.first    = first_ff;
            tag_issue.last_k   = last_y;
            tag_issue.last_all = last_y && last_all_k;
            if (last_y) begin
               if (last_all_k) begin
                  state_in = ST_DRAIN;
               end else begin
                  k_in     = k_next;
                  y_in     = ymin_next_s[AW-1:0];
                  first_in = 1'b1;
               end
            end else begin
               y_in     = y_ff + AW'(1);
               first_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_last_out) begin
               state_in  = ST_LOAD;
               len_a_in  = '0;
               len_b_in  = '0;
               done_a_in = 1'b0;
               done_b_in = 1'b0;
               drop_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         len_a_ff  <= '0;
         len_b_ff  <= '0;
         done_a_ff <= 1'b0;
         done_b_ff <= 1'b0;
         drop_ff   <= 1'b0;
         k_ff      <= '0;
         y_ff      <= '0;
         first_ff  <= 1'b0;
         tag_rd_ff <= '0;
      end else begin
         state_ff  <= state_in;
         len_a_ff  <= len_a_in;
         len_b_ff  <= len_b_in;
         done_a_ff <= done_a_in;
         done_b_ff <= done_b_in;
         drop_ff   <= drop_in;
         k_ff      <= k_in;
         y_ff      <= y_in;
         first_ff  <= first_in;
         tag_rd_ff <= tag_issue;
      end
   end

   pm_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_TERMS)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (len_a_ff[AW-1:0]),
      .wr_data (req_coef_in[COEF_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (data_a)
   );

   pm_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_TERMS)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (len_b_ff[AW-1:0]),
      .wr_data (req_coef_in[COEF_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (data_b)
   );

   pm_mac #(
      .MAX_TERMS  (MAX_TERMS),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .op_a          (data_a),
      .op_b          (data_b),
      .tag           (tag_rd_ff),
      .rsp_valid     (rsp_valid),
      .rsp_coef_out  (rsp_coef_out),
      .rsp_last_out  (rsp_last_out),
      .rsp_saturated (rsp_saturated)
   );

   assign busy              = (state_ff != ST_LOAD);
   assign rsp_terms_dropped = drop_ff;

   // results only come out while a product is in progress
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transfer while idle");

   // the inner index never runs past its upper bound
   a_y_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (y_s <= ymax_s))
      else $error("term index beyond bound");

   // idle never holds two complete operands
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !(done_a_ff && done_b_ff))
      else $error("both operands done while loading");

   // finishing a product clears the operand lengths
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && rsp_valid && rsp_last_out)
         |=> (len_a_ff == '0 && len_b_ff == '0 && !drop_ff))
      else $error("operand state not cleared after product");

endmodule

// ===== verif/polynomial_multiply_check.sv =====
// watches the multiplier ports, predicts every product term and compares it
module polynomial_multiply_check
   import pm_pkg::*;
#(
   parameter int MAX_TERMS  = MAX_TERMS_DEFAULT,
   parameter int COEF_WIDTH = COEF_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_type,
   input  logic [COEF_PORT_WIDTH-1:0] req_coef_in,
   input  logic                       req_last_coef,
   input  logic                       rsp_valid,
   input  logic [RSP_WIDTH-1:0]       rsp_coef_out,
   input  logic                       rsp_last_out,
   input  logic                       rsp_saturated,
   input  logic                       rsp_terms_dropped,
   output int                         mismatch_count,
   output int                         terms_pending
);

   typedef struct packed {
      logic [RSP_WIDTH-1:0] coef;
      logic                 last;
      logic                 sat;
      logic                 dropped;
   } product_term_type;

   localparam logic signed [127:0] TERM_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] TERM_MIN = -128'sh8000_0000_0000_0000;

   product_term_type expected_terms [$];

   // index 0 holds operand a, index 1 operand b
   logic [COEF_PORT_WIDTH-1:0] coefs [2][MAX_TERMS];
   int                         count [2];
   bit                         done  [2];
   bit                         overflowed;

   // q16.16 field of COEF_WIDTH bits, sign extended
   function automatic logic signed [127:0] q_value(logic [COEF_PORT_WIDTH-1:0] raw);
      logic signed [COEF_PORT_WIDTH-1:0] shifted;
      shifted = raw << (COEF_PORT_WIDTH - COEF_WIDTH);
      shifted = shifted >>> (COEF_PORT_WIDTH - COEF_WIDTH);
      return shifted;
   endfunction

   task automatic convolve();
      int                  n;
      logic signed [127:0] acc;
      product_term_type    term;
      n = count[0] + count[1] - 1;
      for (int k = 0; k < n; k++) begin
         acc = '0;
         for (int y = 0; y < count[0]; y++) begin
            if (k - y >= 0 && k - y < count[1])
               acc += q_value(coefs[0][y]) * q_value(coefs[1][k - y]);
         end
         term.last    = (k == n - 1);
         term.dropped = overflowed;
         term.sat     = (acc > TERM_MAX) || (acc < TERM_MIN);
         if (acc > TERM_MAX)
            term.coef = TERM_MAX[63:0];
         else if (acc < TERM_MIN)
            term.coef = TERM_MIN[63:0];
         else
            term.coef = acc[63:0];
         expected_terms.push_back(term);
      end
      count[0]   = 0;
      count[1]   = 0;
      done[0]    = 1'b0;
      done[1]    = 1'b0;
      overflowed = 1'b0;
   endtask

   task automatic take_coefficient(logic is_b, logic [COEF_PORT_WIDTH-1:0] raw,
                                   logic is_last);
      // a complete operand ignores further coefficients until the product goes out
      if (!done[is_b]) begin
         if (count[is_b] < MAX_TERMS) begin
            coefs[is_b][count[is_b]] = raw;
            count[is_b]++;
         end else begin
            overflowed = 1'b1;
         end
         if (is_last)
            done[is_b] = 1'b1;
      end
      if (done[0] && done[1])
         convolve();
   endtask

   task automatic compare_term();
      product_term_type want;
      if (expected_terms.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected product term: coef %h last %b sat %b dropped %b",
                     rsp_coef_out, rsp_last_out, rsp_saturated, rsp_terms_dropped);
      end else begin
         want = expected_terms.pop_front();
         if (rsp_coef_out !== want.coef || rsp_last_out !== want.last ||
             rsp_saturated !== want.sat || rsp_terms_dropped !== want.dropped) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $write("product term mismatch: expected coef %h last %b sat %b dropped %b,",
                      want.coef, want.last, want.sat, want.dropped);
               $display(" got coef %h last %b sat %b dropped %b",
                        rsp_coef_out, rsp_last_out, rsp_saturated, rsp_terms_dropped);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_terms.delete();
         count[0]       = 0;
         count[1]       = 0;
         done[0]        = 1'b0;
         done[1]        = 1'b0;
         overflowed     = 1'b0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid)
            compare_term();
         if (start && !busy)
            take_coefficient(req_type, req_coef_in, req_last_coef);
      end
      terms_pending = expected_terms.size();
   end

endmodule

// ===== verif/polynomial_multiply_test.sv =====
// stimulus and verdict for the polynomial multiplier
module polynomial_multiply_test
   import pm_pkg::*;
();

   // generous bound, far above the slowest legal run
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 55;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_type;
   logic [COEF_PORT_WIDTH-1:0] req_coef_in;
   logic                       req_last_coef;
   logic                       rsp_valid;
   logic [RSP_WIDTH-1:0]       rsp_coef_out;
   logic                       rsp_last_out;
   logic                       rsp_saturated;
   logic                       rsp_terms_dropped;
   int                         mismatch_count;
   int                         terms_pending;
   int                         cycle_count;
   int                         loaded_count;
   int                         pair_count;
   bit                         allow_gaps;

   polynomial_multiply DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_coef_in       (req_coef_in),
      .req_last_coef     (req_last_coef),
      .rsp_valid         (rsp_valid),
      .rsp_coef_out      (rsp_coef_out),
      .rsp_last_out      (rsp_last_out),
      .rsp_saturated     (rsp_saturated),
      .rsp_terms_dropped (rsp_terms_dropped)
   );

   polynomial_multiply_check product_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_coef_in       (req_coef_in),
      .req_last_coef     (req_last_coef),
      .rsp_valid         (rsp_valid),
      .rsp_coef_out      (rsp_coef_out),
      .rsp_last_out      (rsp_last_out),
      .rsp_saturated     (rsp_saturated),
      .rsp_terms_dropped (rsp_terms_dropped),
      .mismatch_count    (mismatch_count),
      .terms_pending     (terms_pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [COEF_PORT_WIDTH-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 19))
         0:       return $urandom_range(MAX_TERMS_DEFAULT + 1, MAX_TERMS_DEFAULT + 3);
         1:       return $urandom_range(7, MAX_TERMS_DEFAULT);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   task automatic send_coef(logic is_b, logic [COEF_PORT_WIDTH-1:0] value, logic is_last);
      int gap;
      gap = 0;
      // each cycle idles with a chance of about 17 in 100
      while (allow_gaps && $urandom_range(99) < 17)
         gap++;
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start         = 1'b1;
      req_type      = is_b;
      req_coef_in   = value;
      req_last_coef = is_last;
      do @(posedge clock); while (busy);
   endtask

   // n copies of one value, the last one marked
   task automatic send_run(logic is_b, int n, logic [COEF_PORT_WIDTH-1:0] value);
      for (int i = 0; i < n; i++)
         send_coef(is_b, value, i == n - 1);
   endtask

   task automatic run_pair(int na, int nb);
      int   sent_a;
      int   sent_b;
      logic pick_b;
      sent_a = 0;
      sent_b = 0;
      while (sent_a < na || sent_b < nb) begin
         if (sent_a == na)
            pick_b = 1'b1;
         else if (sent_b == nb)
            pick_b = 1'b0;
         else
            pick_b = 1'($urandom_range(1));
         // stray transfer to an operand that is already complete
         if (sent_a == na && sent_b < nb && $urandom_range(99) < 5)
            send_coef(1'b0, pick_coef(), 1'($urandom_range(1)));
         else if (sent_b == nb && sent_a < na && $urandom_range(99) < 5)
            send_coef(1'b1, pick_coef(), 1'($urandom_range(1)));
         if (pick_b) begin
            send_coef(1'b1, pick_coef(), sent_b == nb - 1);
            sent_b++;
         end else begin
            send_coef(1'b0, pick_coef(), sent_a == na - 1);
            sent_a++;
         end
         loaded_count++;
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = 1'b0;
      req_coef_in   = '0;
      req_last_coef = 1'b0;
      allow_gaps    = 1'b1;
      loaded_count  = 0;
      pair_count    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single terms at the extremes
      send_coef(1'b0, 32'h7FFF_FFFF, 1'b1);
      send_coef(1'b1, 32'h8000_0000, 1'b1);
      // b first, unequal lengths, a stray b after b is complete
      send_coef(1'b1, 32'h0001_0000, 1'b0);
      send_coef(1'b1, 32'hFFFE_8000, 1'b1);
      send_coef(1'b1, 32'h1234_5678, 1'b1);
      send_coef(1'b0, 32'h0000_8000, 1'b0);
      send_coef(1'b0, 32'h0000_0000, 1'b0);
      send_coef(1'b0, 32'hFFFF_FFFF, 1'b1);
      // equal lengths, middle term clips high
      send_run(1'b0, 2, 32'h8000_0000);
      send_run(1'b1, 2, 32'h8000_0000);
      // middle term clips low
      send_run(1'b0, 3, 32'h8000_0000);
      send_run(1'b1, 3, 32'h7FFF_FFFF);
      // overfilled a store, last mark on a dropped coefficient
      send_run(1'b0, MAX_TERMS_DEFAULT + 2, 32'h0003_4000);
      send_coef(1'b1, 32'h5555_AAAA, 1'b1);

      while (loaded_count < RANDOM_ITEMS) begin
         allow_gaps = !(pair_count >= 2 && pair_count < 5);
         run_pair(pick_length(), pick_length());
         pair_count++;
      end

      @(negedge clock);
      start = 1'b0;
      while (terms_pending != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
